@@ rtl/core/blfs_pkg.sv @@
package blfs_pkg;

  localparam int FREQ_WIDTH = 22;
  localparam int FW = FREQ_WIDTH;
  localparam int LW = 7;
  localparam int AW = 5;

  localparam logic [AW-1:0] ADDR_MIN  = 5'd0;
  localparam logic [AW-1:0] ADDR_MAX  = 5'd4;
  localparam logic [AW-1:0] ADDR_LOWB = 5'd8;
  localparam logic [AW-1:0] ADDR_MIDB = 5'd12;
  localparam logic [AW-1:0] ADDR_HIB  = 5'd16;
  localparam logic [AW-1:0] ADDR_LIM  = 5'd20;

  typedef struct packed {
    logic [LW-1:0] load_percent;
    logic [FW-1:0] current_frequency;
  } blfs_in_t;

  typedef struct packed {
    logic [FW-1:0] next_frequency;
    logic          fast_poll;
  } blfs_out_t;

endpackage

@@ rtl/core/blfs_divider.sv @@
module blfs_divider import blfs_pkg::*; #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  // Restoring divider, one quotient bit per cycle.
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]    trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[W-1:0], q_r[W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ rtl/core/banded_load_to_frequency_selector.sv @@
// Channel | Dir | Handshake        | Beat
// in_     | in  | in_valid/in_stall  | blfs_in_t (load, current kHz)
// out_    | out | out_valid/out_stall| blfs_out_t (next kHz, fast flag)
// cfg_    | in  | APB psel/penable   | 32-bit register write/read
//
// One beat is processed at a time. Divisions run on the shared bit-serial
// restoring divider. With limiting on, four run (position ratio, moving
// average, two window offsets), then a clamp step; with limiting off
// only the ratio runs. Reset is synchronous, active low, and restores the
// register defaults and clears the moving average. The result sits in an
// output register; a new input beat is taken in the cycle after that
// register is read, so a stalled output simply holds the block.
module banded_load_to_frequency_selector import blfs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  blfs_in_t        in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output blfs_out_t       out_data,
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [AW-1:0]   cfg_paddr,
  input  logic [31:0]     cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);

  localparam int DW = FREQ_WIDTH + 18;
  localparam logic [FREQ_WIDTH-1:0] STEP = FREQ_WIDTH'(100000);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RAT  = 7'b0000010,
    S_AVG  = 7'b0000100,
    S_UP   = 7'b0001000,
    S_DN   = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;

  logic [FREQ_WIDTH-1:0] min_r, max_r, avg_r, cur_r, nxt_r, span_r;
  logic [20:0] lowb_r, midb_r, hib_r;
  logic        lim_r, fast_r;
  logic [LW-1:0] load_r;
  logic [6:0]  upw_r;
  logic [FREQ_WIDTH-1:0] upoff_r;

  logic        wr;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr)
      ADDR_MIN:  cfg_prdata = 32'(min_r);
      ADDR_MAX:  cfg_prdata = 32'(max_r);
      ADDR_LOWB: cfg_prdata = 32'(lowb_r);
      ADDR_MIDB: cfg_prdata = 32'(midb_r);
      ADDR_HIB:  cfg_prdata = 32'(hib_r);
      ADDR_LIM:  cfg_prdata = 32'(lim_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // Divider shared across the up to four divisions of a beat.
  logic          dv_start, dv_done;
  logic [DW-1:0] dv_a, dv_b, dv_q;

  blfs_divider #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start),
    .dividend(dv_a), .divisor(dv_b), .done(dv_done), .quotient(dv_q)
  );

  logic [FREQ_WIDTH-1:0] span_c, off_c;
  assign span_c = (max_r > min_r) ? max_r - min_r : '0;
  assign off_c  = (in_data.current_frequency[FREQ_WIDTH-1:0] > min_r) ?
                  in_data.current_frequency[FREQ_WIDTH-1:0] - min_r : '0;

  // Band decision from the ratio quotient.
  logic [20:0] bands;
  logic [6:0]  xl, hl, ll, upw_c;
  logic        fast_c, lowb, midb;
  logic [FREQ_WIDTH:0] upsum;
  logic [FREQ_WIDTH-1:0] next_c;
  always_comb begin
    lowb = (span_r != '0) ? (dv_q < DW'(33)) : 1'b1;
    midb = !lowb && (dv_q < DW'(66));
    bands = lowb ? lowb_r : (midb ? midb_r : hib_r);
    xl = bands[20:14];
    hl = bands[13:7];
    ll = bands[6:0];
    upw_c  = 7'd33;
    fast_c = 1'b0;
    next_c = cur_r;
    upsum  = {1'b0, cur_r} + {1'b0, STEP};
    if (load_r > xl) begin
      next_c = max_r;
      if (lowb) begin
        fast_c = 1'b1; upw_c = 7'd66;
      end else if (midb) begin
        fast_c = 1'b1; upw_c = 7'd50;
      end
    end else if (load_r > hl) begin
      next_c = upsum[FREQ_WIDTH] ? '1 : upsum[FREQ_WIDTH-1:0];
    end else if (load_r < ll) begin
      next_c = (cur_r > STEP) ? cur_r - STEP : '0;
    end
  end

  // Window clamp once the down offset is known.
  logic [FREQ_WIDTH:0]   top_w;
  logic [FREQ_WIDTH-1:0] top_c, bot_c, clamp_c, dnoff;
  always_comb begin
    dnoff = dv_q[FREQ_WIDTH-1:0];
    top_w = {1'b0, avg_r} + {1'b0, upoff_r};
    top_c = (top_w > {1'b0, max_r}) ? max_r : top_w[FREQ_WIDTH-1:0];
    if (dnoff > avg_r || (avg_r - dnoff) < min_r) bot_c = min_r;
    else bot_c = avg_r - dnoff;
    clamp_c = (nxt_r > top_c) ? top_c : nxt_r;
    if (clamp_c < bot_c) clamp_c = bot_c;
  end

  logic accept;
  assign in_stall  = (st_r != S_IDLE);
  assign accept    = in_valid && (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_data.next_frequency = nxt_r;
  assign out_data.fast_poll      = fast_r;

  always_comb begin
    st_nxt   = st_r;
    dv_start = 1'b0;
    dv_a     = '0;
    dv_b     = '0;
    case (st_r)
      S_IDLE: if (accept) begin
        st_nxt = S_RAT; dv_start = 1'b1;
        dv_a = DW'(off_c) * DW'(100);
        dv_b = (span_c == '0) ? DW'(1) : DW'(span_c);
      end
      S_RAT: if (dv_done) begin
        st_nxt = lim_r ? S_AVG : S_OUT;
        dv_start = lim_r;
        dv_a = DW'(avg_r) * DW'(90) + DW'(cur_r) * DW'(10);
        dv_b = DW'(100);
      end
      S_AVG: if (dv_done) begin
        st_nxt = S_UP; dv_start = 1'b1;
        dv_a = DW'(upw_r) * DW'(span_r);
        dv_b = DW'(100);
      end
      S_UP: if (dv_done) begin
        st_nxt = S_DN; dv_start = 1'b1;
        dv_a = DW'(25) * DW'(span_r);
        dv_b = DW'(100);
      end
      S_DN: if (dv_done) st_nxt = S_FIN;
      S_FIN: st_nxt = S_OUT;
      S_OUT: if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      min_r  <= FREQ_WIDTH'(200000);
      max_r  <= FREQ_WIDTH'(1000000);
      lowb_r <= 21'd1612062;
      midb_r <= 21'd1615287;
      hib_r  <= 21'd1650635;
      lim_r  <= 1'b1;
      avg_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (wr) begin
        case (cfg_paddr)
          ADDR_MIN:  min_r  <= cfg_pwdata[FREQ_WIDTH-1:0];
          ADDR_MAX:  max_r  <= cfg_pwdata[FREQ_WIDTH-1:0];
          ADDR_LOWB: lowb_r <= cfg_pwdata[20:0];
          ADDR_MIDB: midb_r <= cfg_pwdata[20:0];
          ADDR_HIB:  hib_r  <= cfg_pwdata[20:0];
          ADDR_LIM:  lim_r  <= cfg_pwdata[0];
          default: ;
        endcase
      end
      if (st_r == S_AVG && dv_done) avg_r <= dv_q[FREQ_WIDTH-1:0];
      if (st_r == S_FIN && upw_r > 7'd33 && clamp_c == top_c) avg_r <= top_c;
    end
    if (accept) begin
      load_r <= in_data.load_percent;
      cur_r  <= in_data.current_frequency[FREQ_WIDTH-1:0];
      span_r <= span_c;
    end
    if (st_r == S_RAT && dv_done) begin
      nxt_r  <= next_c;
      fast_r <= fast_c;
      upw_r  <= upw_c;
    end
    if (st_r == S_UP && dv_done) upoff_r <= dv_q[FREQ_WIDTH-1:0];
    if (st_r == S_FIN) nxt_r <= clamp_c;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  a_fast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fast_poll && !lim_r |-> out_data.next_frequency == max_r)
    else $error("fast flag without jump to max");

endmodule
